FILE: sv/mhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_pkg - shared types for the max-priority heap queue
// Command and status codes, the heap entry, and the item and result structs.
// ----------------------------------------------------------------------------
package mhq_pkg;

	// operation codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int ENTRY_W = 48;

	// one heap entry: process id and signed priority
	typedef struct packed {
		logic [31:0]        id;
		logic signed [15:0] prio;
	} entry_t;

	// input item
	typedef struct packed {
		logic               cmd;
		logic [31:0]        item_id;
		logic signed [15:0] item_prio;
	} in_t;

	// result item
	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        out_id;
		logic signed [15:0] out_prio;
		logic [6:0]         count_after;
	} out_t;

endpackage

FILE: sv/mhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_ram - generic RAM, one write port, two registered read ports
// Contents are not reset; read data appears the cycle after the address.
// ----------------------------------------------------------------------------
module mhq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: sv/max_priority_heap_queue.sv
`timescale 1ns / 1ps
// The heap rebuild uses the shared compare unit and the single write port of the heap RAM.
// One item at a time (busy).
// Reset clears the entry count and the control state; heap RAM is not cleared.
// The result strobe (done) lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// max_priority_heap_queue - max-priority queue held as a binary heap in RAM
// Push appends, pop takes the root and moves the last entry to the root; the whole heap is then rebuilt by
// sifting every inner node from count/2 down to 1 with one compare unit.
// ----------------------------------------------------------------------------
module max_priority_heap_queue #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mhq_pkg::in_t  item,
	output logic          done,
	output mhq_pkg::out_t result
);
	import mhq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DISP, S_POPWR, S_CUR, S_KIDS, S_CMP, S_PUT, S_FIN
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   root_q;
	logic [CW-1:0]   pos_q;
	entry_t          cur_q;
	entry_t          top_q;
	in_t             item_q;
	logic [1:0]      status_q;
	logic            done_q;
	out_t            result_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic [AW-1:0]   ram_ra;
	logic [AW-1:0]   ram_rb;
	logic [ENTRY_W-1:0] ram_rd_a_raw;
	logic [ENTRY_W-1:0] ram_rd_b_raw;
	entry_t          rd_a;
	entry_t          rd_b;

	logic [CW:0]     kid_l;
	logic [CW:0]     kid_r;
	logic            l_ok;
	logic            r_ok;
	logic            take_l;
	logic            take_r;
	logic signed [15:0] big_prio;
	logic [CW:0]     big_pos;
	entry_t          big_val;
	logic            moved;
	logic [CW:0]     nk_l;
	logic            has_kids;
	logic [CW-1:0]   count_inc;
	logic [CW-1:0]   count_dec;

	// one-based heap position to RAM slot
	function automatic logic [AW-1:0] slot_of(input logic [CW:0] p);
		logic [CW:0] t;
		t = p - 1'b1;
		return t[AW-1:0];
	endfunction

	mhq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.rdata_a (ram_rd_a_raw),
		.raddr_b (ram_rb),
		.rdata_b (ram_rd_b_raw)
	);

	assign rd_a = entry_t'(ram_rd_a_raw);
	assign rd_b = entry_t'(ram_rd_b_raw);

	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	// shared compare unit: node held in cur_q against its two children
	always_comb begin
		kid_l    = {pos_q, 1'b0};
		kid_r    = kid_l + 1'b1;
		l_ok     = kid_l <= {1'b0, count_q};
		r_ok     = kid_r <= {1'b0, count_q};
		take_l   = l_ok && (rd_a.prio > cur_q.prio);
		big_prio = take_l ? rd_a.prio : cur_q.prio;
		take_r   = r_ok && (rd_b.prio > big_prio);
		moved    = take_l || take_r;
		big_val  = take_r ? rd_b : rd_a;
		if (take_r) begin
			big_pos = kid_r;
		end else if (take_l) begin
			big_pos = kid_l;
		end else begin
			big_pos = {1'b0, pos_q};
		end
		nk_l     = {big_pos[CW-1:0], 1'b0};
		has_kids = nk_l <= {1'b0, count_q};
	end

	// RAM port control per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_ra    = '0;
		ram_rb    = '0;
		case (state_q)
			S_DISP: begin
				if (item_q.cmd == CMD_PUSH) begin
					ram_we    = (count_q != CW'(DEPTH));
					ram_waddr = count_q[AW-1:0];
					ram_wdata = '{id: item_q.item_id, prio: item_q.item_prio};
				end else begin
					ram_rb = slot_of({1'b0, count_q});
				end
			end
			S_POPWR: begin
				ram_we    = 1'b1;
				ram_wdata = rd_b;
			end
			S_CUR: begin
				ram_ra = slot_of({1'b0, pos_q});
			end
			S_KIDS: begin
				ram_ra = slot_of(kid_l);
				ram_rb = slot_of(kid_r);
			end
			S_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = slot_of({1'b0, pos_q});
				ram_wdata = moved ? big_val : cur_q;
				ram_ra    = slot_of(nk_l);
				ram_rb    = slot_of(nk_l + 1'b1);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = slot_of({1'b0, pos_q});
			end
			default: begin
			end
		endcase
	end

	// sequencer, heap count and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			root_q   <= '0;
			pos_q    <= '0;
			cur_q    <= '0;
			top_q    <= '0;
			item_q   <= '0;
			status_q <= ST_DONE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q   <= item;
						top_q    <= '0;
						status_q <= ST_DONE;
						state_q  <= S_DISP;
					end
				end
				S_DISP: begin
					if (item_q.cmd == CMD_PUSH) begin
						if (count_q == CW'(DEPTH)) begin
							status_q <= ST_FULL;
							state_q  <= S_FIN;
						end else begin
							count_q <= count_inc;
							root_q  <= count_inc >> 1;
							pos_q   <= count_inc >> 1;
							state_q <= ((count_inc >> 1) == '0) ? S_FIN : S_CUR;
						end
					end else if (count_q == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_POPWR;
					end
				end
				S_POPWR: begin
					top_q   <= rd_a;
					count_q <= count_dec;
					root_q  <= count_dec >> 1;
					pos_q   <= count_dec >> 1;
					state_q <= ((count_dec >> 1) == '0) ? S_FIN : S_CUR;
				end
				S_CUR: begin
					state_q <= S_KIDS;
				end
				S_KIDS: begin
					cur_q   <= rd_a;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (moved) begin
						pos_q   <= big_pos[CW-1:0];
						state_q <= has_kids ? S_CMP : S_PUT;
					end else if (root_q == CW'(1)) begin
						state_q <= S_FIN;
					end else begin
						root_q  <= root_q - 1'b1;
						pos_q   <= root_q - 1'b1;
						state_q <= S_CUR;
					end
				end
				S_PUT: begin
					if (root_q == CW'(1)) begin
						state_q <= S_FIN;
					end else begin
						root_q  <= root_q - 1'b1;
						pos_q   <= root_q - 1'b1;
						state_q <= S_CUR;
					end
				end
				S_FIN: begin
					result_q.status      <= status_q;
					result_q.out_id      <= top_q.id;
					result_q.out_prio    <= top_q.prio;
					result_q.count_after <= 7'(count_q);
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: sv/mhq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_checker - port-level checks for the max-priority heap queue
// Watches the command handshake and result strobe; bound to the top level.
// ----------------------------------------------------------------------------
module mhq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input mhq_pkg::out_t result
);
	import mhq_pkg::*;

	// an accepted item raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// a result is only shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// rejected items return a zero entry
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (result.out_id == '0 && result.out_prio == '0))
		else $error("rejected item returned a nonzero entry");

	// an empty-pop reject reports an empty heap
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> (result.count_after == '0))
		else $error("empty reject with nonzero count");

	// one strobe per item, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

endmodule

bind max_priority_heap_queue mhq_checker u_mhq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
